// ===== rtl/core/hsc_pkg.sv =====
// Shared types, constants and lookup functions for the hall six-step commutator.
// Depends on nothing; the commutator core imports it.
package hsc_pkg;

  localparam int PERIOD_BITS = 16;
  localparam int SPEED_BITS  = 29;
  localparam int MISS_BITS   = 16;
  localparam int PULSE_BITS  = 32;
  localparam int DUTY_BITS   = 16;
  localparam int DIV_CNT_BITS = $clog2(SPEED_BITS);

  localparam logic [SPEED_BITS-1:0] SPEED_NUMERATOR = SPEED_BITS'(512000000);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(SPEED_BITS - 1);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MOTOR_ON      = 2'd0,
    CFG_REVERSE_DIR   = 2'd1,
    CFG_PHASE_ADVANCE = 2'd2
  } cfg_idx_t;

  // Phase drive indexes and enable masks.
  localparam logic [1:0] DRIVE_U = 2'd0;
  localparam logic [1:0] DRIVE_V = 2'd1;
  localparam logic [1:0] DRIVE_W = 2'd2;
  localparam logic [2:0] MASK_U  = 3'b001;
  localparam logic [2:0] MASK_V  = 3'b010;
  localparam logic [2:0] MASK_W  = 3'b100;

  // Rotor phase for each hall code; the two illegal codes fall to phase 0.
  function automatic logic [2:0] hsc_hall_phase(input logic [2:0] hall);
    logic [2:0] ph;
    case (hall)
      3'b001:  ph = 3'd2;
      3'b010:  ph = 3'd4;
      3'b011:  ph = 3'd3;
      3'b101:  ph = 3'd1;
      3'b110:  ph = 3'd5;
      default: ph = 3'd0;
    endcase
    return ph;
  endfunction

  function automatic logic [2:0] hsc_phase_fwd(input logic [2:0] ph);
    return (ph >= 3'd5) ? 3'(ph - 3'd5) : 3'(ph + 3'd1);
  endfunction

  function automatic logic [2:0] hsc_phase_back(input logic [2:0] ph);
    return (ph == 3'd0) ? 3'd5 : 3'(ph - 3'd1);
  endfunction

  // Reduces a value below 16 modulo six with two compare-and-subtract steps.
  function automatic logic [2:0] hsc_mod6(input logic [3:0] v);
    logic [3:0] t;
    t = (v >= 4'd12) ? 4'(v - 4'd12) : ((v >= 4'd6) ? 4'(v - 4'd6) : v);
    return t[2:0];
  endfunction

  function automatic logic [1:0] hsc_step_drive(input logic [2:0] step);
    logic [1:0] d;
    case (step)
      3'd0:    d = DRIVE_V;
      3'd1:    d = DRIVE_U;
      3'd2:    d = DRIVE_U;
      3'd3:    d = DRIVE_W;
      3'd4:    d = DRIVE_W;
      default: d = DRIVE_V;
    endcase
    return d;
  endfunction

  function automatic logic [2:0] hsc_step_mask(input logic [2:0] step);
    logic [2:0] m;
    case (step)
      3'd0:    m = MASK_V | MASK_W;
      3'd1:    m = MASK_U | MASK_W;
      3'd2:    m = MASK_U | MASK_V;
      3'd3:    m = MASK_V | MASK_W;
      3'd4:    m = MASK_U | MASK_W;
      default: m = MASK_U | MASK_V;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/core/hall_six_step_commutator_top.sv =====
// Hall six-step commutator: phase tracking, commutation, speed divider, edge counters.
// Depends on hsc_pkg for widths, lookup tables and register indexes.
//
// A hall event that captures a speed passes from the input transfer through the bit-serial
// divider (S_DIV) to S_DONE, which commits the result to the output register; an event
// without a speed capture goes straight to S_DONE. S_DONE waits while the output register
// is full and stalled, and no new event is taken until the last one has committed. The
// radix-2 divider yields one quotient bit per cycle.
// Reset (rst_n low, synchronous) clears configuration, phase history, counters,
// compare values, speed and the output valid flag; both input ports hold off meanwhile.
module hall_six_step_commutator_top
  import hsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,

  // Configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [2:0]             cfg_data,

  // Hall event channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_hall_state,
  input  logic [2:0]             in_edge_lines,
  input  logic [PERIOD_BITS-1:0] in_period_count,
  input  logic                   in_period_overflow,
  input  logic [DUTY_BITS-1:0]   in_duty,

  // Result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DUTY_BITS-1:0]   out_compare_u,
  output logic [DUTY_BITS-1:0]   out_compare_v,
  output logic [DUTY_BITS-1:0]   out_compare_w,
  output logic [2:0]             out_drive_enable,
  output logic [MISS_BITS-1:0]   out_missed_steps,
  output logic [SPEED_BITS-1:0]  out_speed,
  output logic                   out_speed_valid,
  output logic                   out_speed_updated,
  output logic [PULSE_BITS-1:0]  out_pulses_a,
  output logic [PULSE_BITS-1:0]  out_pulses_b,
  output logic [PULSE_BITS-1:0]  out_pulses_c
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t state_r;

  // Configuration registers. Writes must only arrive while the block is idle; the block
  // does not enforce this. The port never pushes back outside reset.
  logic       motor_on_r;
  logic       reverse_r;
  logic [2:0] advance_r;

  // The event being worked on, captured at the input transfer.
  logic [2:0]             hall_q_r;
  logic [2:0]             edge_q_r;
  logic [DUTY_BITS-1:0]   duty_q_r;
  logic                   speed_go_r;

  // Restoring divider: quo_r starts as the numerator and shifts it out MSB first
  // while the quotient bits shift in at the bottom.
  logic [PERIOD_BITS-1:0]  divisor_r;
  logic [PERIOD_BITS-1:0]  rem_r;
  logic [SPEED_BITS-1:0]   quo_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;

  // Persistent block state.
  logic [2:0]            last_phase_r;
  logic                  last_known_r;
  logic [DUTY_BITS-1:0]  compare_r [3];
  logic [MISS_BITS-1:0]  missed_r;
  logic [PULSE_BITS-1:0] pulses_r [3];
  logic [SPEED_BITS-1:0] speed_r;
  logic                  speed_seen_r;

  // Output register.
  logic out_valid_r;

  // Combinational signals.
  logic                   in_xfer;
  logic                   out_free;
  logic [PERIOD_BITS-1:0] period_eff;
  logic                   capture;
  logic [PERIOD_BITS:0]   trial;
  logic                   trial_ge;
  logic [PERIOD_BITS-1:0] rem_nxt;
  logic [SPEED_BITS-1:0]  quo_nxt;
  logic [2:0]             phase_c;
  logic                   adjacent;
  logic [MISS_BITS-1:0]   missed_nxt;
  logic [3:0]             step_sum;
  logic [2:0]             step_c;
  logic [1:0]             drive_idx;
  logic [2:0]             enable_c;
  logic [DUTY_BITS-1:0]   compare_nxt [3];
  logic [PULSE_BITS-1:0]  pulses_nxt [3];

  assign cfg_ready = rst_n;
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  // A speed capture needs an edge on line A with sensor A high and a nonzero
  // period; an overflowed timer counts as the full-scale period.
  assign period_eff = in_period_overflow ? {PERIOD_BITS{1'b1}} : in_period_count;
  assign capture    = in_hall_state[0] && in_edge_lines[0] && (period_eff != '0);

  // One quotient bit per cycle.
  always_comb begin
    trial    = {rem_r, quo_r[SPEED_BITS-1]};
    trial_ge = (trial >= {1'b0, divisor_r});
    rem_nxt  = trial_ge ? PERIOD_BITS'(trial - {1'b0, divisor_r}) : trial[PERIOD_BITS-1:0];
    quo_nxt  = {quo_r[SPEED_BITS-2:0], trial_ge};
  end

  // Commutation and bookkeeping for the held event, applied when it completes.
  always_comb begin
    phase_c    = hsc_hall_phase(hall_q_r);
    adjacent   = (phase_c == hsc_phase_fwd(last_phase_r)) ||
                 (phase_c == hsc_phase_back(last_phase_r));
    missed_nxt = (last_known_r && !adjacent) ? MISS_BITS'(missed_r + 1'b1) : missed_r;

    // Base of 8 forward or 5 reversed keeps the difference non-negative.
    step_sum  = (reverse_r ? 4'd5 : 4'd8) - {1'b0, phase_c} + {1'b0, advance_r};
    step_c    = hsc_mod6(step_sum);
    drive_idx = hsc_step_drive(step_c);
    enable_c  = motor_on_r ? hsc_step_mask(step_c) : 3'b000;

    for (int i = 0; i < 3; i++) begin
      if (motor_on_r) begin
        compare_nxt[i] = (drive_idx == 2'(i)) ? duty_q_r : '0;
      end else begin
        compare_nxt[i] = compare_r[i];
      end
      pulses_nxt[i] = pulses_r[i] + PULSE_BITS'(edge_q_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      motor_on_r   <= 1'b0;
      reverse_r    <= 1'b0;
      advance_r    <= 3'd0;
      last_phase_r <= 3'd0;
      last_known_r <= 1'b0;
      missed_r     <= '0;
      speed_r      <= '0;
      speed_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
      div_cnt_r    <= '0;
      for (int i = 0; i < 3; i++) begin
        compare_r[i] <= '0;
        pulses_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MOTOR_ON:      motor_on_r <= cfg_data[0];
          CFG_REVERSE_DIR:   reverse_r  <= cfg_data[0];
          CFG_PHASE_ADVANCE: advance_r  <= cfg_data;
          default: ;
        endcase
      end

      // The output register fills when a result commits and empties on a result transfer.
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            hall_q_r   <= in_hall_state;
            edge_q_r   <= in_edge_lines;
            duty_q_r   <= in_duty;
            speed_go_r <= capture;
            divisor_r  <= period_eff;
            rem_r      <= '0;
            quo_r      <= SPEED_NUMERATOR;
            div_cnt_r  <= '0;
            state_r    <= capture ? S_DIV : S_DONE;
          end
        end
        S_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          div_cnt_r <= DIV_CNT_BITS'(div_cnt_r + 1'b1);
          if (div_cnt_r == DIV_LAST) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // Commit only once the output register can take the result.
          if (out_free) begin
            last_phase_r <= phase_c;
            last_known_r <= 1'b1;
            missed_r     <= missed_nxt;
            for (int i = 0; i < 3; i++) begin
              compare_r[i] <= compare_nxt[i];
              pulses_r[i]  <= pulses_nxt[i];
            end
            if (speed_go_r) begin
              speed_r      <= quo_r;
              speed_seen_r <= 1'b1;
            end

            out_compare_u     <= compare_nxt[DRIVE_U];
            out_compare_v     <= compare_nxt[DRIVE_V];
            out_compare_w     <= compare_nxt[DRIVE_W];
            out_drive_enable  <= enable_c;
            out_missed_steps  <= missed_nxt;
            out_speed         <= speed_go_r ? quo_r : speed_r;
            out_speed_valid   <= speed_go_r || speed_seen_r;
            out_speed_updated <= speed_go_r;
            out_pulses_a      <= pulses_nxt[0];
            out_pulses_b      <= pulses_nxt[1];
            out_pulses_c      <= pulses_nxt[2];
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/hall_six_step_commutator_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the hall six-step commutator: directed and random hall events.
// Depends on hsc_pkg for widths and register indexes, and on hall_six_step_commutator_top.
module hall_six_step_commutator_top_tb
  import hsc_pkg::*;
();

  // The run is stopped here if the block hangs. The slowest correct run is far below this.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint unsigned SPEED_DIVIDEND = 64'd512000000;
  // Cycles to keep watching the result channel after the last expected transfer.
  localparam int TAIL_CYCLES = 40;
  // Length of the long receiver hold that fills the block up.
  localparam int RX_HOLD_CYCLES = 400;

  // Commutation tables, indexed by step (0..5) or hall code (0..7); index 0 is rightmost.
  localparam logic [5:0][2:0] ENABLE_OF_STEP = {3'b011, 3'b101, 3'b110, 3'b011, 3'b101, 3'b110};
  localparam logic [5:0][1:0] DRIVEN_OF_STEP = {2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};
  localparam logic [7:0][2:0] PHASE_OF_HALL  = {3'd0, 3'd5, 3'd1, 3'd0, 3'd3, 3'd4, 3'd2, 3'd0};
  localparam logic [5:0][2:0] HALL_OF_PHASE  = {3'd6, 3'd2, 3'd3, 3'd1, 3'd5, 3'd4};

  typedef struct {
    logic [2:0]             hall;
    logic [2:0]             edges;
    logic [PERIOD_BITS-1:0] period;
    logic                   overflow;
    logic [DUTY_BITS-1:0]   duty;
  } hall_event_t;

  typedef struct {
    logic [DUTY_BITS-1:0]  cmp_u;
    logic [DUTY_BITS-1:0]  cmp_v;
    logic [DUTY_BITS-1:0]  cmp_w;
    logic [2:0]            enable;
    logic [MISS_BITS-1:0]  missed;
    logic [SPEED_BITS-1:0] speed;
    logic                  speed_valid;
    logic                  speed_updated;
    logic [PULSE_BITS-1:0] pulses_a;
    logic [PULSE_BITS-1:0] pulses_b;
    logic [PULSE_BITS-1:0] pulses_c;
  } commutation_t;

  // How a random phase treats the two handshakes.
  typedef enum {PH_PLAIN, PH_NO_IDLE, PH_RX_HOLD, PH_TX_PAUSE} phase_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [2:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [2:0]             in_hall_state = '0;
  logic [2:0]             in_edge_lines = '0;
  logic [PERIOD_BITS-1:0] in_period_count = '0;
  logic                   in_period_overflow = 1'b0;
  logic [DUTY_BITS-1:0]   in_duty = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DUTY_BITS-1:0]   out_compare_u;
  logic [DUTY_BITS-1:0]   out_compare_v;
  logic [DUTY_BITS-1:0]   out_compare_w;
  logic [2:0]             out_drive_enable;
  logic [MISS_BITS-1:0]   out_missed_steps;
  logic [SPEED_BITS-1:0]  out_speed;
  logic                   out_speed_valid;
  logic                   out_speed_updated;
  logic [PULSE_BITS-1:0]  out_pulses_a;
  logic [PULSE_BITS-1:0]  out_pulses_b;
  logic [PULSE_BITS-1:0]  out_pulses_c;

  hall_six_step_commutator_top i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_hall_state      (in_hall_state),
    .in_edge_lines      (in_edge_lines),
    .in_period_count    (in_period_count),
    .in_period_overflow (in_period_overflow),
    .in_duty            (in_duty),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_compare_u      (out_compare_u),
    .out_compare_v      (out_compare_v),
    .out_compare_w      (out_compare_w),
    .out_drive_enable   (out_drive_enable),
    .out_missed_steps   (out_missed_steps),
    .out_speed          (out_speed),
    .out_speed_valid    (out_speed_valid),
    .out_speed_updated  (out_speed_updated),
    .out_pulses_a       (out_pulses_a),
    .out_pulses_b       (out_pulses_b),
    .out_pulses_c       (out_pulses_c)
  );

  always #6 clk = ~clk;

  // Shadow copy of the configuration registers, updated on each register write transfer.
  logic       reg_motor_on = 1'b0;
  logic       reg_reverse  = 1'b0;
  logic [2:0] reg_advance  = '0;

  // Shadow copy of the commutator state.
  int                    trk_phase = 0;
  bit                    trk_known = 1'b0;
  logic [DUTY_BITS-1:0]  cmp_val [3] = '{default: '0};
  logic [MISS_BITS-1:0]  miss_cnt = '0;
  logic [PULSE_BITS-1:0] pulse_cnt [3] = '{default: '0};
  logic [SPEED_BITS-1:0] spd_val = '0;
  logic                  spd_seen = 1'b0;

  hall_event_t  queued_events[$];
  commutation_t predicted_outputs[$];

  // Transfer bookkeeping. The driver bumps offered and accepted counts in the same process
  // that pushes predictions, so the stimulus process always sees a consistent picture.
  int unsigned queued_count = 0;
  int unsigned offered_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  bit send_gaps = 1'b0;
  bit recv_gaps = 1'b0;
  bit send_hold = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int hold_left = 0;

  // Random walk state used to build realistic rotor sequences.
  int         walk_phase = 0;
  int         walk_dir = 1;
  logic [2:0] walk_hall = 3'd4;

  // Computes the result that one hall event must produce and advances the shadow state.
  function automatic commutation_t predict_commutation(hall_event_t ev);
    commutation_t           r;
    int                     ph;
    int                     step;
    logic [PERIOD_BITS-1:0] per;
    bit                     updated;
    ph = int'(PHASE_OF_HALL[ev.hall]);
    updated = 1'b0;
    r.enable = 3'b000;
    // A repeated phase or a jump of more than one step counts as a missed step.
    // The first event after reset has nothing to compare against.
    if (trk_known && ph != (trk_phase + 1) % 6 && ph != (trk_phase + 5) % 6) begin
      miss_cnt = miss_cnt + 1'b1;
    end
    trk_phase = ph;
    trk_known = 1'b1;
    // With the motor off the compare values are held and no phase is enabled.
    if (reg_motor_on) begin
      step = ((reg_reverse ? 5 : 8) - ph + int'(reg_advance)) % 6;
      cmp_val = '{default: '0};
      cmp_val[DRIVEN_OF_STEP[step]] = ev.duty;
      r.enable = ENABLE_OF_STEP[step];
    end
    // Speed is captured only on an edge of line A while sensor A reads high.
    if (ev.hall[0] && ev.edges[0]) begin
      per = ev.overflow ? '1 : ev.period;
      if (per != '0) begin
        spd_val = SPEED_BITS'(SPEED_DIVIDEND / per);
        spd_seen = 1'b1;
        updated = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (ev.edges[i]) begin
        pulse_cnt[i] = pulse_cnt[i] + 1'b1;
      end
    end
    r.cmp_u = cmp_val[0];
    r.cmp_v = cmp_val[1];
    r.cmp_w = cmp_val[2];
    r.missed = miss_cnt;
    r.speed = spd_val;
    r.speed_valid = spd_seen;
    r.speed_updated = updated;
    r.pulses_a = pulse_cnt[0];
    r.pulses_b = pulse_cnt[1];
    r.pulses_c = pulse_cnt[2];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Builds one random event. Most events follow the rotor walk in the current direction,
  // a few reverse it, repeat the last code or are plain noise.
  function automatic hall_event_t make_event();
    hall_event_t ev;
    int          pick;
    logic [2:0]  nxt;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      nxt = HALL_OF_PHASE[(walk_phase + walk_dir) % 6];
      ev.edges = nxt ^ walk_hall;
    end else if (pick < 88) begin
      walk_dir = 6 - walk_dir;
      nxt = HALL_OF_PHASE[(walk_phase + walk_dir) % 6];
      ev.edges = nxt ^ walk_hall;
    end else if (pick < 93) begin
      nxt = walk_hall;
      ev.edges = 3'($urandom_range(0, 7));
    end else begin
      nxt = 3'($urandom_range(0, 7));
      ev.edges = 3'($urandom_range(0, 7));
    end
    ev.hall = nxt;
    walk_hall = nxt;
    walk_phase = int'(PHASE_OF_HALL[nxt]);
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      ev.period = '0;
    end else if (pick < 12) begin
      ev.period = '1;
    end else if (pick < 40) begin
      ev.period = PERIOD_BITS'($urandom_range(1, 255));
    end else begin
      ev.period = PERIOD_BITS'($urandom_range(0, 65535));
    end
    ev.overflow = ($urandom_range(0, 99) < 6);
    ev.duty = DUTY_BITS'($urandom_range(0, 65535));
    return ev;
  endfunction

  function automatic void queue_event(logic [2:0] hall, logic [2:0] edges,
                                      logic [PERIOD_BITS-1:0] period, logic overflow,
                                      logic [DUTY_BITS-1:0] duty);
    hall_event_t ev;
    ev.hall = hall;
    ev.edges = edges;
    ev.period = period;
    ev.overflow = overflow;
    ev.duty = duty;
    queued_events.push_back(ev);
    queued_count++;
  endfunction

  // Returns once every queued event has been transferred and every result has come back.
  task automatic wait_drained();
    while (accepted_count != queued_count || predicted_outputs.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes all three registers in back-to-back transfers. Valid is raised once and kept
  // high until the last transfer, so it never gets two updates in one time step.
  task automatic program_regs(logic on, logic rev, logic [2:0] adv);
    cfg_idx_t   idx;
    logic [2:0] val;
    for (int i = 0; i < 3; i++) begin
      case (i)
        0:       begin idx = CFG_MOTOR_ON;      val = {2'b00, on};  end
        1:       begin idx = CFG_REVERSE_DIR;   val = {2'b00, rev}; end
        default: begin idx = CFG_PHASE_ADVANCE; val = adv;          end
      endcase
      cfg_index <= idx;
      cfg_data <= val;
      if (i == 0) begin
        cfg_valid <= 1'b1;
      end
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      case (idx)
        CFG_MOTOR_ON:    reg_motor_on = val[0];
        CFG_REVERSE_DIR: reg_reverse = val[0];
        default:         reg_advance = val;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // One random phase: reprogram while idle, then stream events shaped by the mode.
  task automatic run_phase(logic on, logic rev, logic [2:0] adv, int count, phase_mode_t mode);
    hall_event_t ev;
    wait_drained();
    program_regs(on, rev, adv);
    send_gaps = (mode != PH_NO_IDLE);
    recv_gaps = (mode != PH_NO_IDLE);
    walk_dir = ($urandom_range(0, 1) != 0) ? 1 : 5;
    for (int i = 0; i < count; i++) begin
      ev = make_event();
      queue_event(ev.hall, ev.edges, ev.period, ev.overflow, ev.duty);
    end
    // The receiver holds off on its own count while the sender keeps offering events.
    if (mode == PH_RX_HOLD) begin
      hold_req++;
    end
    // Halfway through, the sender stops until every outstanding result has come back.
    if (mode == PH_TX_PAUSE) begin
      while (queued_events.size() > count / 2) begin
        @(posedge clk);
      end
      send_hold = 1'b1;
      while (offered_count != accepted_count || predicted_outputs.size() != 0) begin
        @(posedge clk);
      end
      send_hold = 1'b0;
    end
  endtask

  // Input driver. Inputs change only right after a rising edge and a stalled transfer
  // keeps its payload. Each accepted event is predicted at the edge of its transfer.
  always @(posedge clk) begin
    hall_event_t acc_ev;
    hall_event_t nxt_ev;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        acc_ev.hall = in_hall_state;
        acc_ev.edges = in_edge_lines;
        acc_ev.period = in_period_count;
        acc_ev.overflow = in_period_overflow;
        acc_ev.duty = in_duty;
        predicted_outputs.push_back(predict_commutation(acc_ev));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_events.size() != 0 && !send_hold &&
            !(send_gaps && $urandom_range(0, 99) < 34)) begin
          nxt_ev = queued_events.pop_front();
          in_valid <= 1'b1;
          in_hall_state <= nxt_ev.hall;
          in_edge_lines <= nxt_ev.edges;
          in_period_count <= nxt_ev.period;
          in_period_overflow <= nxt_ev.overflow;
          in_duty <= nxt_ev.duty;
          offered_count++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver. Each result transfer is checked against the oldest
  // prediction; the stall it drives for the next cycle is random or a long hold.
  always @(posedge clk) begin
    commutation_t exp_res;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_outputs.size() == 0) begin
          $error("result transfer with no event outstanding");
          error_count++;
        end else begin
          exp_res = predicted_outputs.pop_front();
          check_field("compare_u", 32'(exp_res.cmp_u), 32'(out_compare_u));
          check_field("compare_v", 32'(exp_res.cmp_v), 32'(out_compare_v));
          check_field("compare_w", 32'(exp_res.cmp_w), 32'(out_compare_w));
          check_field("drive_enable", 32'(exp_res.enable), 32'(out_drive_enable));
          check_field("missed_steps", 32'(exp_res.missed), 32'(out_missed_steps));
          check_field("speed", 32'(exp_res.speed), 32'(out_speed));
          check_field("speed_valid", 32'(exp_res.speed_valid), 32'(out_speed_valid));
          check_field("speed_updated", 32'(exp_res.speed_updated), 32'(out_speed_updated));
          check_field("pulses_a", exp_res.pulses_a, out_pulses_a);
          check_field("pulses_b", exp_res.pulses_b, out_pulses_b);
          check_field("pulses_c", exp_res.pulses_c, out_pulses_c);
        end
      end
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = RX_HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= recv_gaps && ($urandom_range(0, 99) < 34);
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Registers still at reset: the motor is off, so compare values stay zero and nothing
    // is enabled. The first event has no previous phase, so it never counts as missed.
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    queue_event(3'd5, 3'b001, 16'd0, 1'b0, 16'h1234);    // zero period on a capture edge
    queue_event(3'd4, 3'b111, 16'd1000, 1'b0, 16'hFFFF); // sensor A low, no capture
    queue_event(3'd1, 3'b001, 16'd0, 1'b1, 16'h0001);    // overflow counts as full scale

    // Motor on, forward mapping, no advance: walk all phases and hit the corner cases.
    wait_drained();
    program_regs(1'b1, 1'b0, 3'd0);
    queue_event(3'd4, 3'b000, 16'd100, 1'b0, 16'hFFFF);
    queue_event(3'd5, 3'b001, 16'd1, 1'b0, 16'h0000);     // shortest period, top speed
    queue_event(3'd1, 3'b100, 16'hFFFF, 1'b0, 16'h5555);  // no edge on line A
    queue_event(3'd3, 3'b010, 16'd777, 1'b0, 16'hAAAA);
    queue_event(3'd2, 3'b001, 16'd500, 1'b0, 16'h00FF);   // edge on A but sensor A low
    queue_event(3'd6, 3'b100, 16'd321, 1'b0, 16'hFF00);
    queue_event(3'd4, 3'b010, 16'd42, 1'b0, 16'h0F0F);
    queue_event(3'd4, 3'b000, 16'd42, 1'b0, 16'hF0F0);    // repeated phase
    queue_event(3'd0, 3'b100, 16'd9, 1'b0, 16'h1111);     // illegal code, same phase 0
    queue_event(3'd7, 3'b111, 16'd0, 1'b0, 16'h2222);     // illegal code, zero period held
    queue_event(3'd7, 3'b001, 16'd0, 1'b1, 16'h3333);     // overflow with a zero count
    queue_event(3'd5, 3'b001, 16'hFFFF, 1'b0, 16'h4444);  // longest plain period
    queue_event(3'd2, 3'b111, 16'd3, 1'b0, 16'h6666);     // skips two phases
    queue_event(3'd3, 3'b001, 16'd12345, 1'b1, 16'h7777); // overflow overrides the count
    queue_event(3'd1, 3'b010, 16'd88, 1'b0, 16'h8000);    // walking backward
    queue_event(3'd5, 3'b100, 16'd200, 1'b0, 16'h9999);
    queue_event(3'd4, 3'b001, 16'd1, 1'b0, 16'hBBBB);
    queue_event(3'd6, 3'b010, 16'd65, 1'b0, 16'hCCCC);
    queue_event(3'd5, 3'b111, 16'hFFFF, 1'b1, 16'h7FFF);

    // Random phases across the register space, including the unused advance codes 6 and 7.
    // One phase runs with no idling at all on either side.
    run_phase(1'b1, 1'b0, 3'd3, 66, PH_PLAIN);
    run_phase(1'b1, 1'b1, 3'd0, 66, PH_NO_IDLE);
    run_phase(1'b1, 1'b1, 3'd5, 66, PH_RX_HOLD);
    run_phase(1'b0, 1'b1, 3'd2, 66, PH_PLAIN);
    run_phase(1'b1, 1'b0, 3'd6, 66, PH_TX_PAUSE);
    run_phase(1'b1, 1'b1, 3'd7, 66, PH_PLAIN);
    run_phase(1'b1, 1'b0, 3'd1, 66, PH_PLAIN);
    run_phase(1'b0, 1'b0, 3'd4, 66, PH_PLAIN);

    // Let everything drain, then watch a little longer for stray result transfers.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/hsc_pkg.sv
rtl/core/hall_six_step_commutator_top.sv
tb/sv/hall_six_step_commutator_top_tb.sv
